### rtl/lrse_pkg.sv
`timescale 1ns / 1ps

package lrse_pkg;

  // Default sizing
  localparam int NUM_STATES_DEF   = 64;
  localparam int NUM_TOKENS_DEF   = 8;
  localparam int NUM_NONTERMS_DEF = 8;
  localparam int STACK_DEPTH_DEF  = 128;
  localparam int MAX_REDUCES_DEF  = 63;

  // Field widths fixed by the port list
  localparam int REQ_W   = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 3;
  localparam int KIND_W  = 2;
  localparam int POP_W   = 4;
  localparam int EVENT_W = 3;
  localparam int DEPTH_W = 7;
  localparam int COUNT_W = 6;

  // Request types
  localparam logic [REQ_W-1:0] REQ_ACTION = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GOTO   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TOKEN  = 2'd2;

  // Action kinds
  localparam logic [KIND_W-1:0] K_ERROR  = 2'd0;
  localparam logic [KIND_W-1:0] K_SHIFT  = 2'd1;
  localparam logic [KIND_W-1:0] K_REDUCE = 2'd2;
  localparam logic [KIND_W-1:0] K_ACCEPT = 2'd3;

  // Result events
  localparam logic [EVENT_W-1:0] EV_WRITTEN   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_REDUCED   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_SHIFTED   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_ACCEPTED  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_SYNTAX    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_OVERFLOW  = 3'd5;
  localparam logic [EVENT_W-1:0] EV_UNDERFLOW = 3'd6;
  localparam logic [EVENT_W-1:0] EV_LIMIT     = 3'd7;

  // Action table entry: pop[14:11], head[10:8], target[7:2], kind[1:0]
  typedef struct packed {
    logic [POP_W-1:0]   pop;
    logic [SYM_W-1:0]   head;
    logic [STATE_W-1:0] target;
    logic [KIND_W-1:0]  kind;
  } action_entry_t;

  localparam int ACT_W = $bits(action_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_BELOW = 4'b0100,
    ST_GOTO  = 4'b1000
  } lrse_state_t;

endpackage

### rtl/lr_shift_reduce_engine_top.sv
// Flow: a table write transfers its result in the cycle after acceptance; a token runs
//   through ST_EXEC to its registered final result, and through ST_BELOW, ST_GOTO, ST_EXEC per reduce.
// Throughput: one table write per cycle while idle; a new token is taken only after the last
//   ends, as it runs the action-read / stack-read / goto-read loop through the three RAMs.
// Reset clears the stack pointer and top state (start state 0 at index 0); the action and
//   goto tables hold no value until written. The receiver cannot stall results.
`timescale 1ns / 1ps

module lr_shift_reduce_engine_top #(
  parameter int NUM_STATES   = lrse_pkg::NUM_STATES_DEF,
  parameter int NUM_TOKENS   = lrse_pkg::NUM_TOKENS_DEF,
  parameter int NUM_NONTERMS = lrse_pkg::NUM_NONTERMS_DEF,
  parameter int STACK_DEPTH  = lrse_pkg::STACK_DEPTH_DEF,
  parameter int MAX_REDUCES  = lrse_pkg::MAX_REDUCES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrse_pkg::REQ_W-1:0]    in_req_type,
  input  logic [lrse_pkg::STATE_W-1:0]  in_state_index,
  input  logic [lrse_pkg::SYM_W-1:0]    in_symbol,
  input  logic [lrse_pkg::KIND_W-1:0]   in_action_kind,
  input  logic [lrse_pkg::STATE_W-1:0]  in_target_state,
  input  logic [lrse_pkg::SYM_W-1:0]    in_head_symbol,
  input  logic [lrse_pkg::POP_W-1:0]    in_pop_count,
  output logic                          out_strobe,
  output logic [lrse_pkg::EVENT_W-1:0]  out_event_res,
  output logic [lrse_pkg::SYM_W-1:0]    out_rule_head,
  output logic [lrse_pkg::POP_W-1:0]    out_rule_length,
  output logic [lrse_pkg::STATE_W-1:0]  out_top_state,
  output logic [lrse_pkg::DEPTH_W-1:0]  out_stack_depth,
  output logic                          out_last
);

  import lrse_pkg::*;

  localparam int ACT_DEPTH  = NUM_STATES * NUM_TOKENS;
  localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMS;
  localparam int AAW        = $clog2(ACT_DEPTH);
  localparam int GAW        = $clog2(GOTO_DEPTH);
  localparam int SPW        = $clog2(STACK_DEPTH);

  // Control state
  lrse_state_t         state_r, state_nxt;
  logic [STATE_W-1:0]  top_r, top_nxt;          // copy of the state on top of stack
  logic [SPW-1:0]      sp_r, sp_nxt;            // index of the top entry
  logic [COUNT_W-1:0]  red_cnt_r, red_cnt_nxt;  // reduces done for the current token

  // Per-token working registers
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [SYM_W-1:0]    ah_r, ah_nxt;
  logic [POP_W-1:0]    ap_r, ap_nxt;
  logic [SPW-1:0]      spn_r, spn_nxt;          // stack index left after the pop
  logic                act_oor_r, act_oor_nxt;  // lookup outside the action table
  logic                goto_oor_r, goto_oor_nxt;

  // Result register
  logic                out_strobe_r, out_strobe_nxt;
  logic [EVENT_W-1:0]  out_event_r, out_event_nxt;
  logic [SYM_W-1:0]    out_head_r, out_head_nxt;
  logic [POP_W-1:0]    out_len_r, out_len_nxt;
  logic [STATE_W-1:0]  out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;
  logic                out_last_r, out_last_nxt;

  // RAM ports
  logic                act_we, act_re;
  logic [AAW-1:0]      act_waddr, act_raddr;
  logic [ACT_W-1:0]    act_rdata;
  logic                goto_we, goto_re;
  logic [GAW-1:0]      goto_waddr, goto_raddr;
  logic [STATE_W-1:0]  goto_rdata;
  logic                stk_we, stk_re;
  logic [SPW-1:0]      stk_waddr, stk_raddr;
  logic [STATE_W-1:0]  stk_wdata, stk_rdata;

  // End-of-run request from the execute step
  logic                run_end;
  logic [EVENT_W-1:0]  run_ev;
  action_entry_t       ent;
  logic [STATE_W-1:0]  below;
  logic [STATE_W-1:0]  goto_st;

  // Action table: one entry per (state, token)
  lrse_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH)) u_action_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (ACT_W'({in_pop_count, in_head_symbol, in_target_state, in_action_kind})),
    .re    (act_re),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  // Goto table: one entry per (state, nonterminal)
  lrse_ram #(.WIDTH(STATE_W), .DEPTH(GOTO_DEPTH)) u_goto_ram (
    .clk   (clk),
    .we    (goto_we),
    .waddr (goto_waddr),
    .wdata (in_target_state),
    .re    (goto_re),
    .raddr (goto_raddr),
    .rdata (goto_rdata)
  );

  // State stack. Index 0 is never written: it always reads as start state 0, which the
  // below-state select supplies directly. A write and a read never fall in the same cycle.
  lrse_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign act_waddr  = AAW'(32'(in_state_index) * NUM_TOKENS + 32'(in_symbol));
  assign goto_waddr = GAW'(32'(in_state_index) * NUM_NONTERMS + 32'(in_symbol));

  assign busy = (state_r != ST_IDLE);

  // Decoded action entry; an out-of-range lookup reads as an error entry
  assign ent = act_oor_r ? action_entry_t'('0) : action_entry_t'(act_rdata);

  // State under the popped entries; the bottom entry is always state 0
  assign below = (spn_r == '0) ? '0 : stk_rdata;

  // Goto target; a below state outside the table reads as state 0
  assign goto_st = goto_oor_r ? '0 : goto_rdata;

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    sp_nxt         = sp_r;
    red_cnt_nxt    = red_cnt_r;
    sym_nxt        = sym_r;
    ah_nxt         = ah_r;
    ap_nxt         = ap_r;
    spn_nxt        = spn_r;
    act_oor_nxt    = act_oor_r;
    goto_oor_nxt   = goto_oor_r;

    out_strobe_nxt = 1'b0;
    out_event_nxt  = out_event_r;
    out_head_nxt   = '0;
    out_len_nxt    = '0;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_last_nxt   = 1'b0;

    act_we     = 1'b0;
    act_re     = 1'b0;
    act_raddr  = '0;
    goto_we    = 1'b0;
    goto_re    = 1'b0;
    goto_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = '0;

    run_end = 1'b0;
    run_ev  = EV_SYNTAX;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_ACTION, REQ_GOTO: begin
              // Drop writes outside the table, but answer them all the same
              if (in_req_type == REQ_ACTION) begin
                act_we = (32'(in_state_index) < NUM_STATES) &&
                         (32'(in_symbol) < NUM_TOKENS);
              end else begin
                goto_we = (32'(in_state_index) < NUM_STATES) &&
                          (32'(in_symbol) < NUM_NONTERMS);
              end
              out_strobe_nxt = 1'b1;
              out_event_nxt  = EV_WRITTEN;
              out_top_nxt    = top_r;
              out_depth_nxt  = DEPTH_W'(sp_r);
              out_last_nxt   = 1'b1;
            end
            REQ_TOKEN: begin
              // Start the first action lookup for the token
              sym_nxt     = in_symbol;
              red_cnt_nxt = '0;
              act_re      = 1'b1;
              act_raddr   = AAW'(32'(top_r) * NUM_TOKENS + 32'(in_symbol));
              act_oor_nxt = !((32'(top_r) < NUM_STATES) && (32'(in_symbol) < NUM_TOKENS));
              state_nxt   = ST_EXEC;
            end
            default: begin
              // Unused request type: no result
            end
          endcase
        end
      end

      ST_EXEC: begin
        case (ent.kind)
          K_SHIFT: begin
            if (32'(sp_r) + 1 >= STACK_DEPTH) begin
              run_end = 1'b1;
              run_ev  = EV_OVERFLOW;
            end else begin
              // Push the target and finish the token
              stk_we         = 1'b1;
              stk_waddr      = sp_r + SPW'(1);
              stk_wdata      = ent.target;
              sp_nxt         = sp_r + SPW'(1);
              top_nxt        = ent.target;
              out_strobe_nxt = 1'b1;
              out_event_nxt  = EV_SHIFTED;
              out_top_nxt    = ent.target;
              out_depth_nxt  = DEPTH_W'(sp_r + SPW'(1));
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          K_ACCEPT: begin
            run_end = 1'b1;
            run_ev  = EV_ACCEPTED;
          end
          K_REDUCE: begin
            if (32'(red_cnt_r) >= MAX_REDUCES) begin
              run_end = 1'b1;
              run_ev  = EV_LIMIT;
            end else if (32'(ent.pop) > 32'(sp_r)) begin
              run_end = 1'b1;
              run_ev  = EV_UNDERFLOW;
            end else if (32'(ent.head) >= NUM_NONTERMS) begin
              run_end = 1'b1;
              run_ev  = EV_SYNTAX;
            end else if (32'(sp_r) - 32'(ent.pop) + 1 >= STACK_DEPTH) begin
              run_end = 1'b1;
              run_ev  = EV_OVERFLOW;
            end else begin
              // Pop, then fetch the state left underneath
              ah_nxt    = ent.head;
              ap_nxt    = ent.pop;
              spn_nxt   = SPW'(32'(sp_r) - 32'(ent.pop));
              stk_re    = 1'b1;
              stk_raddr = SPW'(32'(sp_r) - 32'(ent.pop));
              state_nxt = ST_BELOW;
            end
          end
          default: begin
            run_end = 1'b1;
            run_ev  = EV_SYNTAX;
          end
        endcase
      end

      ST_BELOW: begin
        // Look up the goto for (below state, rule head)
        goto_re      = 1'b1;
        goto_raddr   = GAW'(32'(below) * NUM_NONTERMS + 32'(ah_r));
        goto_oor_nxt = !(32'(below) < NUM_STATES);
        state_nxt    = ST_GOTO;
      end

      ST_GOTO: begin
        // Push the goto state, report the reduce and look up the action again
        stk_we         = 1'b1;
        stk_waddr      = spn_r + SPW'(1);
        stk_wdata      = goto_st;
        sp_nxt         = spn_r + SPW'(1);
        top_nxt        = goto_st;
        red_cnt_nxt    = red_cnt_r + COUNT_W'(1);
        out_strobe_nxt = 1'b1;
        out_event_nxt  = EV_REDUCED;
        out_head_nxt   = ah_r;
        out_len_nxt    = ap_r;
        out_top_nxt    = goto_st;
        out_depth_nxt  = DEPTH_W'(spn_r + SPW'(1));
        out_last_nxt   = 1'b0;
        act_re         = 1'b1;
        act_raddr      = AAW'(32'(goto_st) * NUM_TOKENS + 32'(sym_r));
        act_oor_nxt    = !((32'(goto_st) < NUM_STATES) && (32'(sym_r) < NUM_TOKENS));
        state_nxt      = ST_EXEC;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Accept and every error end the run: back to start state 0 at index 0
    if (run_end) begin
      sp_nxt         = '0;
      top_nxt        = '0;
      out_strobe_nxt = 1'b1;
      out_event_nxt  = run_ev;
      out_top_nxt    = '0;
      out_depth_nxt  = '0;
      out_last_nxt   = 1'b1;
      state_nxt      = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      top_r        <= '0;
      sp_r         <= '0;
      red_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      sp_r         <= sp_nxt;
      red_cnt_r    <= red_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    ah_r        <= ah_nxt;
    ap_r        <= ap_nxt;
    spn_r       <= spn_nxt;
    act_oor_r   <= act_oor_nxt;
    goto_oor_r  <= goto_oor_nxt;
    out_event_r <= out_event_nxt;
    out_head_r  <= out_head_nxt;
    out_len_r   <= out_len_nxt;
    out_top_r   <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_event_res   = out_event_r;
  assign out_rule_head   = out_head_r;
  assign out_rule_length = out_len_r;
  assign out_top_state   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_last        = out_last_r;

endmodule

### rtl/lrse_ram.sv
`timescale 1ns / 1ps

module lrse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
